FILE: rtl/core/sfcd_pkg.sv
// Package for the framed command deframer: codes, item record, CRC-8 step.
// No dependencies; used by sync_framed_command_deframer.
package sfcd_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'h52;
	localparam logic [7:0] VERSION_BYTE = 8'h01;
	localparam logic [7:0] CRC_POLY     = 8'h07;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_LEGACY = 2'd0,
		KIND_GOOD   = 2'd1,
		KIND_BADCRC = 2'd2,
		KIND_BADLEN = 2'd3
	} kind_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_VERSION = 3'd2,
		PH_OPCODE  = 3'd3,
		PH_LENGTH  = 3'd4,
		PH_BODY    = 3'd5,
		PH_CRC     = 3'd6,
		PH_SKIP    = 3'd7
	} phase_t;

	// Result sequencer states
	typedef enum logic [1:0] {
		EM_IDLE   = 2'd0,
		EM_LEGACY = 2'd1,
		EM_READ   = 2'd2,
		EM_LOAD   = 2'd3
	} emit_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [7:0]  opcode;
		logic [7:0]  length;
		logic        present;
		logic        last;
	} item_t;

	// CRC-8, poly 0x07, MSB first, one byte per call
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/sfcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/sync_framed_command_deframer.sv
// Framed command deframer top level: parser, payload RAM, result sequencer.
// Depends on sfcd_pkg and sfcd_ram.
//
// Usage: bytes from the link enter on rx_byte with in_valid/in_stall; result
// items leave on kind/data_byte/frame_opcode/frame_len/payload_present/
// last with out_valid/out_stall. A frame is 0x52 0x52 0x01 opcode length
// payload crc8. cfg_wr_en/cfg_wr_data set legacy pass-through; the user
// writes it only while idle, not enforced by the block. Throughput: one
// byte per cycle while no multi-item output is pending and the output is
// not stalled. A byte that yields a single item shows it in the cycle
// after its transfer, held in the output register; the next byte is taken
// in the same cycle the item is taken. With pass-through on, a failed
// prefix gives two or three legacy items, one per cycle while the output
// is not stalled, input stalled meanwhile. A good frame is released from
// payload RAM, a read then an output load per byte; input stalls throughout.
// Reset clears the parser to sync hunt and disables pass-through; the
// payload RAM is not cleared (every entry is written before it is read).
// A stall on the output holds the current item and, through in_stall,
// back-pressures the input.
module sync_framed_command_deframer #(
	parameter int MAX_PAYLOAD = 64,
	localparam int LW = $clog2(MAX_PAYLOAD + 1),
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_opcode,
	output logic [7:0] frame_len,
	output logic       payload_present,
	output logic       last
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	// State registers
	logic                   legacy_en_q;
	sfcd_pkg::phase_t       phase_q, ph_d;
	logic [7:0]             crc_q, crc_d, crc_next;
	logic [LW-1:0]          bytes_held_q, bh_d, bh_inc;
	logic [7:0]             held_op_q, op_d;
	logic [LW-1:0]          held_len_q, len_d;
	logic [8:0]             skip_q, skip_d, skip_dec;

	sfcd_pkg::emit_t        emit_q, emit_d;
	logic [1:0]             leg_cnt_q, leg_cnt_d;
	logic [7:0]             leg_byte_q;
	logic [LW-1:0]          rd_idx_q, rd_inc;

	sfcd_pkg::item_t        out_q, item_d, load_item;
	logic                   out_valid_q;

	logic in_accept, out_free, out_load;
	logic new_item, leg_start, rel_start, ram_we, ram_re;
	logic leg_step, rel_last;
	logic [7:0] ram_rdata;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (emit_q != sfcd_pkg::EM_IDLE) || (out_valid_q && out_stall);

	// Parser: next state and the item produced by this byte
	always_comb begin
		ph_d      = phase_q;
		crc_d     = crc_q;
		bh_d      = bytes_held_q;
		op_d      = held_op_q;
		len_d     = held_len_q;
		skip_d    = skip_q;
		item_d    = '0;
		item_d.kind = sfcd_pkg::KIND_LEGACY;
		new_item  = 1'b0;
		leg_start = 1'b0;
		leg_cnt_d = 2'd0;
		rel_start = 1'b0;
		ram_we    = 1'b0;
		crc_next  = sfcd_pkg::crc8_update(crc_q, rx_byte);
		bh_inc    = bytes_held_q + LW'(1);
		skip_dec  = (skip_q != 9'd0) ? skip_q - 9'd1 : 9'd0;
		case (phase_q)
			sfcd_pkg::PH_SYNC1: begin
				if (rx_byte == sfcd_pkg::SYNC_BYTE) begin
					crc_d = sfcd_pkg::crc8_update(8'h00, rx_byte);
					ph_d  = sfcd_pkg::PH_SYNC2;
				end else if (legacy_en_q) begin
					new_item    = 1'b1;
					item_d.data = rx_byte;
					item_d.last = 1'b1;
				end
			end
			sfcd_pkg::PH_SYNC2: begin
				if (rx_byte == sfcd_pkg::SYNC_BYTE) begin
					crc_d = crc_next;
					ph_d  = sfcd_pkg::PH_VERSION;
				end else begin
					// held sync first, then the offending byte
					if (legacy_en_q) begin
						new_item    = 1'b1;
						item_d.data = sfcd_pkg::SYNC_BYTE;
						leg_start   = 1'b1;
						leg_cnt_d   = 2'd1;
					end
					ph_d  = sfcd_pkg::PH_SYNC1;
					bh_d  = '0;
					crc_d = '0;
				end
			end
			sfcd_pkg::PH_VERSION: begin
				if (rx_byte == sfcd_pkg::VERSION_BYTE) begin
					crc_d = crc_next;
					ph_d  = sfcd_pkg::PH_OPCODE;
				end else begin
					if (legacy_en_q) begin
						new_item    = 1'b1;
						item_d.data = sfcd_pkg::SYNC_BYTE;
						leg_start   = 1'b1;
						leg_cnt_d   = 2'd2;
					end
					ph_d  = sfcd_pkg::PH_SYNC1;
					bh_d  = '0;
					crc_d = '0;
				end
			end
			sfcd_pkg::PH_OPCODE: begin
				op_d  = rx_byte;
				crc_d = crc_next;
				ph_d  = sfcd_pkg::PH_LENGTH;
			end
			sfcd_pkg::PH_LENGTH: begin
				crc_d = crc_next;
				if (rx_byte > MAX_LEN) begin
					new_item      = 1'b1;
					item_d.kind   = sfcd_pkg::KIND_BADLEN;
					item_d.opcode = held_op_q;
					item_d.length = rx_byte;
					item_d.last   = 1'b1;
					skip_d        = {1'b0, rx_byte} + 9'd1;
					ph_d          = sfcd_pkg::PH_SKIP;
				end else begin
					len_d = rx_byte[LW-1:0];
					bh_d  = '0;
					ph_d  = (rx_byte == 8'h00) ? sfcd_pkg::PH_CRC : sfcd_pkg::PH_BODY;
				end
			end
			sfcd_pkg::PH_BODY: begin
				ram_we = 1'b1;
				crc_d  = crc_next;
				bh_d   = bh_inc;
				if (bh_inc >= held_len_q) begin
					ph_d = sfcd_pkg::PH_CRC;
				end
			end
			sfcd_pkg::PH_CRC: begin
				if (rx_byte != crc_q) begin
					new_item      = 1'b1;
					item_d.kind   = sfcd_pkg::KIND_BADCRC;
					item_d.opcode = held_op_q;
					item_d.length = 8'(held_len_q);
					item_d.last   = 1'b1;
				end else if (held_len_q == '0) begin
					new_item      = 1'b1;
					item_d.kind   = sfcd_pkg::KIND_GOOD;
					item_d.opcode = held_op_q;
					item_d.last   = 1'b1;
				end else begin
					rel_start = 1'b1;
				end
				ph_d  = sfcd_pkg::PH_SYNC1;
				bh_d  = '0;
				crc_d = '0;
			end
			sfcd_pkg::PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 9'd0) begin
					ph_d  = sfcd_pkg::PH_SYNC1;
					bh_d  = '0;
					crc_d = '0;
				end
			end
			default: begin
				ph_d  = sfcd_pkg::PH_SYNC1;
				bh_d  = '0;
				crc_d = '0;
			end
		endcase
	end

	// Payload store: written during the body, read only during release
	// (input is stalled then), so write and read never overlap.
	sfcd_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (in_accept && ram_we),
		.waddr (bytes_held_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_inc   = rd_idx_q + LW'(1);
	assign rel_last = (rd_inc == held_len_q);

	// Sequencer next state
	always_comb begin
		emit_d = emit_q;
		case (emit_q)
			sfcd_pkg::EM_IDLE: begin
				if (in_accept && leg_start) begin
					emit_d = sfcd_pkg::EM_LEGACY;
				end else if (in_accept && rel_start) begin
					emit_d = sfcd_pkg::EM_READ;
				end
			end
			sfcd_pkg::EM_LEGACY: begin
				if (out_free && leg_cnt_q == 2'd1) begin
					emit_d = sfcd_pkg::EM_IDLE;
				end
			end
			sfcd_pkg::EM_READ: begin
				if (out_free) begin
					emit_d = sfcd_pkg::EM_LOAD;
				end
			end
			sfcd_pkg::EM_LOAD: begin
				emit_d = rel_last ? sfcd_pkg::EM_IDLE : sfcd_pkg::EM_READ;
			end
			default: emit_d = sfcd_pkg::EM_IDLE;
		endcase
	end

	// Sequencer outputs: what goes into the output register
	always_comb begin
		out_load  = 1'b0;
		load_item = item_d;
		ram_re    = 1'b0;
		leg_step  = 1'b0;
		case (emit_q)
			sfcd_pkg::EM_IDLE: begin
				out_load = in_accept && new_item;
			end
			sfcd_pkg::EM_LEGACY: begin
				if (out_free) begin
					out_load          = 1'b1;
					leg_step          = 1'b1;
					load_item         = '0;
					load_item.kind    = sfcd_pkg::KIND_LEGACY;
					load_item.data    = (leg_cnt_q == 2'd1) ? leg_byte_q : sfcd_pkg::SYNC_BYTE;
					load_item.last    = (leg_cnt_q == 2'd1);
				end
			end
			sfcd_pkg::EM_READ: begin
				ram_re = out_free;
			end
			sfcd_pkg::EM_LOAD: begin
				out_load          = 1'b1;
				load_item.kind    = sfcd_pkg::KIND_GOOD;
				load_item.data    = ram_rdata;
				load_item.opcode  = held_op_q;
				load_item.length  = 8'(held_len_q);
				load_item.present = 1'b1;
				load_item.last    = rel_last;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legacy_en_q  <= 1'b0;
			phase_q      <= sfcd_pkg::PH_SYNC1;
			crc_q        <= '0;
			bytes_held_q <= '0;
			held_op_q    <= '0;
			held_len_q   <= '0;
			skip_q       <= '0;
			emit_q       <= sfcd_pkg::EM_IDLE;
			leg_cnt_q    <= '0;
			rd_idx_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				legacy_en_q <= cfg_wr_data;
			end
			if (in_accept) begin
				phase_q      <= ph_d;
				crc_q        <= crc_d;
				bytes_held_q <= bh_d;
				held_op_q    <= op_d;
				held_len_q   <= len_d;
				skip_q       <= skip_d;
			end
			emit_q <= emit_d;
			if (in_accept && leg_start) begin
				leg_cnt_q <= leg_cnt_d;
			end else if (leg_step) begin
				leg_cnt_q <= leg_cnt_q - 2'd1;
			end
			if (in_accept && rel_start) begin
				rd_idx_q <= '0;
			end else if (emit_q == sfcd_pkg::EM_LOAD) begin
				rd_idx_q <= rd_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			leg_byte_q <= rx_byte;
		end
		if (out_load) begin
			out_q <= load_item;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_q.kind;
	assign data_byte       = out_q.data;
	assign frame_opcode    = out_q.opcode;
	assign frame_len       = out_q.length;
	assign payload_present = out_q.present;
	assign last            = out_q.last;

	// Checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("output item overwritten while stalled");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_q == sfcd_pkg::EM_READ) |-> (rd_idx_q < held_len_q))
		else $error("payload read beyond frame length");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_q == sfcd_pkg::EM_LOAD) |-> ($past(emit_q) == sfcd_pkg::EM_READ))
		else $error("payload load without preceding RAM read");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sfcd_pkg::PH_SKIP) |-> (skip_q != 9'd0))
		else $error("skip phase with empty count");

endmodule
